// ----- src/tfsbd_pkg.sv -----
package tfsbd_pkg;

	localparam int TASK_W      = 32;
	localparam int CNT_W       = 6;
	localparam int MAX_RESULTS = 32;

	localparam logic [CNT_W-1:0] OFFER_LIMIT_RST = 6'd10;

	localparam logic [1:0] ACT_QUERY = 2'd0;
	localparam logic [1:0] ACT_PUSH  = 2'd1;
	localparam logic [1:0] ACT_POP   = 2'd2;

	typedef struct packed {
		logic                     vld;
		logic signed [TASK_W-1:0] val;
	} cell_t;

	typedef struct packed {
		logic ins;
		logic drain;
	} sort_ctrl_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SETTLE,
		ST_DRAIN
	} state_t;

endpackage

// ----- src/tfsbd_cell.sv -----
module tfsbd_cell (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tfsbd_pkg::sort_ctrl_t             ctrl,
	input  logic signed [tfsbd_pkg::TASK_W-1:0] din,
	input  tfsbd_pkg::cell_t                  left,
	input  logic                              left_lt,
	input  tfsbd_pkg::cell_t                  right,
	output tfsbd_pkg::cell_t                  q,
	output logic                              lt
);
	import tfsbd_pkg::*;

	logic                     vld_q;
	logic signed [TASK_W-1:0] val_q;

	assign q = '{vld: vld_q, val: val_q};

	// an empty cell acts as +infinity
	always_comb begin
		lt = !vld_q || (din < val_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (ctrl.ins) begin
			if (left_lt) begin
				vld_q <= left.vld;
			end else if (lt) begin
				vld_q <= 1'b1;
			end
		end else if (ctrl.drain) begin
			vld_q <= right.vld;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (left_lt) begin
				val_q <= left.val;
			end else if (lt) begin
				val_q <= din;
			end
		end else if (ctrl.drain) begin
			val_q <= right.val;
		end
	end

endmodule

// ----- src/tfsbd_sorter.sv -----
module tfsbd_sorter (
	input  logic                                clk,
	input  logic                                arst_n,
	input  tfsbd_pkg::sort_ctrl_t               ctrl,
	input  logic signed [tfsbd_pkg::TASK_W-1:0] din,
	output tfsbd_pkg::cell_t                    head
);
	import tfsbd_pkg::*;

	cell_t cells [MAX_RESULTS];
	logic  lts   [MAX_RESULTS];

	// insert: every cell compares with din in parallel, larger entries move right
	// drain: the row shifts left, cell 0 is the smallest
	for (genvar i = 0; i < MAX_RESULTS; i++) begin : g_cell
		cell_t left_c;
		logic  left_lt_c;
		cell_t right_c;

		if (i == 0) begin : g_first
			assign left_c    = '0;
			assign left_lt_c = 1'b0;
		end else begin : g_mid
			assign left_c    = cells[i-1];
			assign left_lt_c = lts[i-1];
		end

		if (i == MAX_RESULTS-1) begin : g_last
			assign right_c = '0;
		end else begin : g_nxt
			assign right_c = cells[i+1];
		end

		tfsbd_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctrl    (ctrl),
			.din     (din),
			.left    (left_c),
			.left_lt (left_lt_c),
			.right   (right_c),
			.q       (cells[i]),
			.lt      (lts[i])
		);
	end

	assign head = cells[0];

endmodule

// ----- src/task_fifo_sorted_batch_dequeue_core.sv -----
// Task FIFO with sorted batch dequeue. An item is taken when start is high and busy
// is low; each result is shown for one cycle with done high and cannot be held off.
// For query and push the result appears in the next cycle and busy stays low, so
// items may follow back to back. A pop of n = min(occupancy, request_count, 32) tasks
// keeps busy high while it reads the store through its single read port and inserts
// each task into the 32-cell sorting chain, passes a settle state, then drains the
// chain head, one result per cycle with last on the final one. A pop of nothing gives
// a single result in the next cycle. Configuration writes are always accepted
// (cfg_ready is tied high).
module task_fifo_sorted_batch_dequeue_core #(
	parameter int CAPACITY = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	output logic                                busy,
	input  logic [1:0]                          action,
	input  logic signed [tfsbd_pkg::TASK_W-1:0] task_in,
	input  logic                                batch_end,
	input  logic [tfsbd_pkg::CNT_W-1:0]         request_count,
	output logic                                done,
	output logic                                task_valid,
	output logic signed [tfsbd_pkg::TASK_W-1:0] task_out,
	output logic                                last,
	output logic [tfsbd_pkg::CNT_W-1:0]         free_offer,
	output logic [tfsbd_pkg::CNT_W-1:0]         drop_count,
	output logic                                overflow,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [tfsbd_pkg::CNT_W-1:0]         cfg_data
);
	import tfsbd_pkg::*;

	localparam int PTR_W = $clog2(CAPACITY);
	localparam int OCC_W = $clog2(CAPACITY + 1);
	localparam int CW    = (OCC_W > CNT_W) ? OCC_W : CNT_W;

	logic signed [TASK_W-1:0] mem [CAPACITY];

	state_t             state_q, state_d;
	logic [PTR_W-1:0]   head_q, tail_q;
	logic [OCC_W-1:0]   occ_q;
	logic [CNT_W-1:0]   limit_q;
	logic [CNT_W-1:0]   rem_q;
	logic [CNT_W-1:0]   cnt_q;
	logic               rd_vld_s1;
	logic signed [TASK_W-1:0] rd_data_s1;

	logic               accept;
	logic               full;
	logic [CW-1:0]      occ_w, req_w, lim_w, free_w, take_w;
	logic [CNT_W-1:0]   n_take;
	logic [CNT_W-1:0]   offer_c, drop_c;
	sort_ctrl_t         sctrl;
	cell_t              sort_head;

	assign cfg_ready = 1'b1;
	assign accept    = start && !busy;
	assign full      = (occ_q == OCC_W'(CAPACITY));

	always_comb begin
		occ_w  = CW'(occ_q);
		req_w  = CW'(request_count);
		lim_w  = CW'(limit_q);
		free_w = CW'(CAPACITY) - occ_w;
		take_w = (occ_w < req_w) ? occ_w : req_w;
		if (take_w > CW'(MAX_RESULTS)) begin
			take_w = CW'(MAX_RESULTS);
		end
		n_take  = CNT_W'(take_w);
		offer_c = (free_w < lim_w) ? CNT_W'(free_w) : limit_q;
		drop_c  = (lim_w > free_w) ? CNT_W'(lim_w - free_w) : '0;
	end

	// next state and sorter control
	always_comb begin
		state_d     = state_q;
		busy        = 1'b0;
		sctrl.ins   = rd_vld_s1;
		sctrl.drain = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && action == ACT_POP && n_take != '0) begin
					state_d = ST_LOAD;
				end
			end
			ST_LOAD: begin
				busy = 1'b1;
				if (rem_q == CNT_W'(1)) begin
					state_d = ST_SETTLE;
				end
			end
			ST_SETTLE: begin
				busy    = 1'b1;
				state_d = ST_DRAIN;
			end
			ST_DRAIN: begin
				busy        = 1'b1;
				sctrl.drain = 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= OFFER_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= cfg_data;
		end
	end

	// store: one write port for pushes, one registered read port for pops
	always_ff @(posedge clk) begin
		if (accept && action == ACT_PUSH && !full) begin
			mem[tail_q] <= task_in;
		end
		rd_data_s1 <= mem[head_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q     <= '0;
			tail_q     <= '0;
			occ_q      <= '0;
			rem_q      <= '0;
			cnt_q      <= '0;
			rd_vld_s1  <= 1'b0;
			done       <= 1'b0;
			task_valid <= 1'b0;
			task_out   <= '0;
			last       <= 1'b0;
			free_offer <= '0;
			drop_count <= '0;
			overflow   <= 1'b0;
		end else begin
			rd_vld_s1  <= (state_q == ST_LOAD);
			done       <= 1'b0;
			task_valid <= 1'b0;
			task_out   <= '0;
			last       <= 1'b0;
			free_offer <= '0;
			drop_count <= '0;
			overflow   <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						case (action)
							ACT_QUERY: begin
								done       <= 1'b1;
								last       <= 1'b1;
								free_offer <= offer_c;
								drop_count <= drop_c;
							end
							ACT_PUSH: begin
								done <= 1'b1;
								last <= 1'b1;
								if (full) begin
									overflow <= 1'b1;
								end else begin
									tail_q <= (tail_q == PTR_W'(CAPACITY-1)) ? '0 :
										tail_q + 1'b1;
									occ_q  <= occ_q + 1'b1;
								end
							end
							ACT_POP: begin
								if (n_take == '0) begin
									done <= 1'b1;
									last <= 1'b1;
								end else begin
									rem_q <= n_take;
									cnt_q <= n_take;
									occ_q <= occ_q - OCC_W'(n_take);
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_LOAD: begin
					head_q <= (head_q == PTR_W'(CAPACITY-1)) ? '0 : head_q + 1'b1;
					rem_q  <= rem_q - 1'b1;
				end
				ST_SETTLE: begin
				end
				ST_DRAIN: begin
					done       <= 1'b1;
					task_valid <= 1'b1;
					task_out   <= sort_head.val;
					last       <= (cnt_q == CNT_W'(1));
					cnt_q      <= cnt_q - 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	tfsbd_sorter u_sorter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (sctrl),
		.din    (rd_data_s1),
		.head   (sort_head)
	);

endmodule

// ----- src/tfsbd_checker.sv -----
module tfsbd_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                start,
	input logic                                busy,
	input logic [1:0]                          action,
	input logic                                done,
	input logic                                task_valid,
	input logic                                last,
	input logic [tfsbd_pkg::CNT_W-1:0]         free_offer,
	input logic [tfsbd_pkg::CNT_W-1:0]         drop_count,
	input logic                                overflow
);
	import tfsbd_pkg::*;

	// a batch streams without gaps until its last task
	a_batch_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !last) |=> done)
		else $error("batch result stream broke before last");

	// status-only results are single
	a_status_single: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !task_valid) |-> last)
		else $error("non-task result without last");

	a_task_fields_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(done && task_valid) |-> (free_offer == '0 && drop_count == '0 && !overflow))
		else $error("task result carries query or push status");

	a_busy_in_batch: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !last) |-> busy)
		else $error("block idle while batch still draining");

	a_pop_responds: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && action == ACT_POP) |=> (done || busy))
		else $error("pop request neither answered nor started");

endmodule

bind task_fifo_sorted_batch_dequeue_core tfsbd_checker u_tfsbd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.start      (start),
	.busy       (busy),
	.action     (action),
	.done       (done),
	.task_valid (task_valid),
	.last       (last),
	.free_offer (free_offer),
	.drop_count (drop_count),
	.overflow   (overflow)
);
